// ===== design/assert_macros.svh =====
// Assertion macros used by the converter top level; they assume clk and rst_n are in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RHC_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rgb_to_hsv check failed");

// Next-cycle implication, checked outside reset.
`define RHC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rgb_to_hsv check failed");

`endif

// ===== design/rhc_pkg.sv =====
// Constants, types and codes shared by the RGB to HSV converter modules.
`default_nettype none

package rhc_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;

    // Hue constants in 1/2^HUE_FRAC_BITS degree units.
    localparam int HUE_SIXTY = 60 << HUE_FRAC_BITS;
    localparam int HUE_120   = 120 << HUE_FRAC_BITS;
    localparam int HUE_240   = 240 << HUE_FRAC_BITS;
    localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;
    localparam int HUE_W     = $clog2(HUE_FULL);

    // Quotient widths of the two divisions and the shared divider geometry.
    localparam int HQ_W       = $clog2(HUE_SIXTY + 1);
    localparam int QUO_W      = (CHANNEL_BITS > HQ_W) ? CHANNEL_BITS : HQ_W;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    localparam int QUO_PAD    = DIV_STAGES * DIV_STEP;
    localparam int NUM_W      = CHANNEL_BITS + QUO_PAD;

    // Two front stages, the divider stages and the output stage.
    localparam int PIPE_STAGES = DIV_STAGES + 3;

    localparam logic [HUE_W-1:0] HUE_120_W  = HUE_W'(HUE_120);
    localparam logic [HUE_W-1:0] HUE_240_W  = HUE_W'(HUE_240);
    localparam logic [HUE_W-1:0] HUE_FULL_W = HUE_W'(HUE_FULL);
    localparam logic [NUM_W-1:0] HUE_SIXTY_N = NUM_W'(HUE_SIXTY);

    typedef logic [1:0] sector_t;

    localparam sector_t SEC_RED   = 2'd0;
    localparam sector_t SEC_GREEN = 2'd1;
    localparam sector_t SEC_BLUE  = 2'd2;

    // One lane of the restoring divider: divisor, partial remainder and the
    // numerator bits that turn into quotient bits as they shift out.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] den;
        logic [CHANNEL_BITS-1:0] pr;
        logic [QUO_PAD-1:0]      nq;
    } div_lane_t;

    typedef struct packed {
        div_lane_t sat;
        div_lane_t hue;
        sector_t   sector;
        logic      neg;
    } div_word_t;

    // Load enables of every pipeline register stage.
    typedef struct packed {
        logic                  f1;
        logic                  f2;
        logic [DIV_STAGES-1:0] div;
        logic                  back;
    } pipe_en_t;

endpackage

`default_nettype wire

// ===== design/rgb_to_hsv_converter.sv =====
// Top level of the pipelined RGB to HSV converter.
`default_nettype none
`include "assert_macros.svh"

// Converts one RGB pixel per clock into brightness (largest channel),
// saturation (FULL*(max-min)/max, truncated) and hue in 1/64 degree units,
// with hue_defined low and hue zero for gray pixels. The pipeline is
// PIPE_STAGES = DIV_STAGES + 3 register stages deep; at the default widths
// these are two front stages, six divider stages that each retire two
// quotient bits of the 12-bit hue quotient (the saturation quotient runs
// alongside), and the output register. A new word is taken every cycle while
// pix_stall is low; while hsv_stall is high, empty stages keep filling and
// pix_stall rises only once every stage holds a word.
module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    pix_valid,
    output logic                         pix_stall,
    input  wire logic [CHANNEL_BITS-1:0] red,
    input  wire logic [CHANNEL_BITS-1:0] green,
    input  wire logic [CHANNEL_BITS-1:0] blue,
    output logic                         hsv_valid,
    input  wire logic                    hsv_stall,
    output logic [HUE_W-1:0]             hue,
    output logic                         hue_defined,
    output logic [CHANNEL_BITS-1:0]      saturation,
    output logic [CHANNEL_BITS-1:0]      brightness
);

    pipe_en_t  en;
    div_word_t div_chain [DIV_STAGES+1];

    rhc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .en        (en)
    );

    rhc_front u_front
    (
        .clk   (clk),
        .en    (en),
        .red   (red),
        .green (green),
        .blue  (blue),
        .word  (div_chain[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        rhc_div_stage u_div_stage
        (
            .clk      (clk),
            .en       (en.div[k]),
            .word_in  (div_chain[k]),
            .word_out (div_chain[k+1])
        );
    end

    rhc_back u_back
    (
        .clk         (clk),
        .en          (en.back),
        .word        (div_chain[DIV_STAGES]),
        .hue         (hue),
        .hue_defined (hue_defined),
        .saturation  (saturation),
        .brightness  (brightness)
    );

    `RHC_ASSERT_IMP(a_gray_hue_zero, hsv_valid && !hue_defined, hue == '0)
    `RHC_ASSERT_IMP(a_defined_sat, hsv_valid && hue_defined, saturation != '0)
    `RHC_ASSERT_IMP(a_hue_range, hsv_valid, hue < HUE_FULL_W)
    `RHC_ASSERT_IMP(a_stall_cause, pix_stall, hsv_valid && hsv_stall)
    `RHC_ASSERT_NEXT(a_stall_keeps_word, pix_stall, hsv_valid)

endmodule

`default_nettype wire

// ===== design/rhc_ctrl.sv =====
// Valid bits and stall chain of the converter pipeline.
`default_nettype none

module rhc_ctrl
    import rhc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pix_valid,
    output logic      pix_stall,
    output logic      hsv_valid,
    input  wire logic hsv_stall,
    output pipe_en_t  en
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] ready;

    // A stage may load when it is empty or when the stage after it moves on,
    // so bubbles are squeezed out while the output is stalled.
    always_comb
    begin
        ready[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || !hsv_stall;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? pix_valid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        en.f1   = ready[0];
        en.f2   = ready[1];
        en.div  = ready[DIV_STAGES+1:2];
        en.back = ready[PIPE_STAGES-1];
    end

    assign pix_stall = !ready[0];
    assign hsv_valid = valid_reg[PIPE_STAGES-1];

endmodule

`default_nettype wire

// ===== design/rhc_front.sv =====
// Front stages: channel extremes, sextant, hue difference and both numerators.
`default_nettype none

module rhc_front
    import rhc_pkg::*;
(
    input  wire logic                    clk,
    input  wire pipe_en_t                en,
    input  wire logic [CHANNEL_BITS-1:0] red,
    input  wire logic [CHANNEL_BITS-1:0] green,
    input  wire logic [CHANNEL_BITS-1:0] blue,
    output div_word_t                    word
);

    logic                    r_ge_g;
    logic                    r_ge_b;
    logic                    g_ge_b;
    logic                    g_ge_r;
    logic                    b_ge_r;
    logic                    b_ge_g;
    sector_t                 sector_next;
    logic [CHANNEL_BITS-1:0] mx_next;
    logic [CHANNEL_BITS-1:0] mn_next;
    logic [CHANNEL_BITS-1:0] sub_a;
    logic [CHANNEL_BITS-1:0] sub_b;
    logic [CHANNEL_BITS:0]   diff;
    logic                    neg_next;
    logic [CHANNEL_BITS-1:0] adiff_next;

    sector_t                 sector_reg;
    logic [CHANNEL_BITS-1:0] mx_reg;
    logic [CHANNEL_BITS-1:0] mn_reg;
    logic                    neg_reg;
    logic [CHANNEL_BITS-1:0] adiff_reg;

    logic [CHANNEL_BITS-1:0] del;
    logic [NUM_W-1:0]        sat_num;
    logic [NUM_W-1:0]        hue_num;
    div_word_t               word_next;
    div_word_t               word_reg;

    // Stage one: compare the channels. Ties go to red, then to green.
    always_comb
    begin
        r_ge_g = red >= green;
        r_ge_b = red >= blue;
        g_ge_b = green >= blue;
        g_ge_r = green >= red;
        b_ge_r = blue >= red;
        b_ge_g = blue >= green;

        if (r_ge_g && r_ge_b)
        begin
            sector_next = SEC_RED;
        end
        else if (g_ge_b)
        begin
            sector_next = SEC_GREEN;
        end
        else
        begin
            sector_next = SEC_BLUE;
        end

        if (g_ge_r && b_ge_r)
        begin
            mn_next = red;
        end
        else if (b_ge_g)
        begin
            mn_next = green;
        end
        else
        begin
            mn_next = blue;
        end

        case (sector_next)
            SEC_RED:
            begin
                mx_next = red;
                sub_a   = green;
                sub_b   = blue;
            end
            SEC_GREEN:
            begin
                mx_next = green;
                sub_a   = blue;
                sub_b   = red;
            end
            default:
            begin
                mx_next = blue;
                sub_a   = red;
                sub_b   = green;
            end
        endcase

        diff       = {1'b0, sub_a} - {1'b0, sub_b};
        neg_next   = diff[CHANNEL_BITS];
        adiff_next = neg_next ? CHANNEL_BITS'(-diff) : diff[CHANNEL_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.f1)
        begin
            sector_reg <= sector_next;
            mx_reg     <= mx_next;
            mn_reg     <= mn_next;
            neg_reg    <= neg_next;
            adiff_reg  <= adiff_next;
        end
    end

    // Stage two: FULL*del for saturation and 60 degrees times |diff| for hue.
    always_comb
    begin
        del     = mx_reg - mn_reg;
        sat_num = (NUM_W'(del) << CHANNEL_BITS) - NUM_W'(del);
        hue_num = NUM_W'(adiff_reg) * HUE_SIXTY_N;

        word_next.sat.den = mx_reg;
        word_next.sat.pr  = sat_num[NUM_W-1 -: CHANNEL_BITS];
        word_next.sat.nq  = sat_num[QUO_PAD-1:0];
        word_next.hue.den = del;
        word_next.hue.pr  = hue_num[NUM_W-1 -: CHANNEL_BITS];
        word_next.hue.nq  = hue_num[QUO_PAD-1:0];
        word_next.sector  = sector_reg;
        word_next.neg     = neg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.f2)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// ===== design/rhc_div_stage.sv =====
// One stage of the pipelined restoring divider, both lanes side by side.
`default_nettype none

module rhc_div_stage
    import rhc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire div_word_t word_in,
    output div_word_t      word_out
);

    div_word_t word_next;
    div_word_t word_reg;

    // One quotient bit: shift the next numerator bit into the remainder and
    // subtract the divisor when it fits.
    function automatic div_lane_t div_step(input div_lane_t lane);
        logic [CHANNEL_BITS:0]   sh;
        logic [CHANNEL_BITS+1:0] dif;
        logic                    fits;
        div_lane_t               res;
        sh   = {lane.pr, lane.nq[QUO_PAD-1]};
        dif  = {1'b0, sh} - {2'b00, lane.den};
        fits = !dif[CHANNEL_BITS+1];
        res.den = lane.den;
        res.pr  = fits ? dif[CHANNEL_BITS-1:0] : sh[CHANNEL_BITS-1:0];
        res.nq  = {lane.nq[QUO_PAD-2:0], fits};
        return res;
    endfunction

    always_comb
    begin
        word_next = word_in;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            word_next.sat = div_step(word_next.sat);
            word_next.hue = div_step(word_next.hue);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

`default_nettype wire

// ===== design/rhc_back.sv =====
// Output stage: sextant offset, sign fix-up of the hue and the output registers.
`default_nettype none

module rhc_back
    import rhc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire div_word_t               word,
    output logic [HUE_W-1:0]             hue,
    output logic                         hue_defined,
    output logic [CHANNEL_BITS-1:0]      saturation,
    output logic [CHANNEL_BITS-1:0]      brightness
);

    logic [HQ_W-1:0]         q;
    logic [HUE_W-1:0]        q_ext;
    logic                    rem_nz;
    logic                    del_nz;
    logic [CHANNEL_BITS-1:0] sat_q;
    logic [HUE_W-1:0]        hue_raw;

    logic [HUE_W-1:0]        hue_next;
    logic                    hue_defined_next;
    logic [CHANNEL_BITS-1:0] saturation_next;

    logic [HUE_W-1:0]        hue_reg;
    logic                    hue_defined_reg;
    logic [CHANNEL_BITS-1:0] saturation_reg;
    logic [CHANNEL_BITS-1:0] brightness_reg;

    // For green and blue the offset keeps the angle positive, so a negative
    // difference rounds down; for red it truncates toward zero and wraps.
    always_comb
    begin
        q      = word.hue.nq[HQ_W-1:0];
        q_ext  = HUE_W'(q);
        rem_nz = |word.hue.pr;
        del_nz = |word.hue.den;
        sat_q  = word.sat.nq[CHANNEL_BITS-1:0];

        case (word.sector)
            SEC_RED:
            begin
                if (!word.neg)
                begin
                    hue_raw = q_ext;
                end
                else if (q_ext == '0)
                begin
                    hue_raw = '0;
                end
                else
                begin
                    hue_raw = HUE_FULL_W - q_ext;
                end
            end
            SEC_GREEN:
            begin
                hue_raw = word.neg ? HUE_120_W - q_ext - HUE_W'(rem_nz)
                                   : HUE_120_W + q_ext;
            end
            SEC_BLUE:
            begin
                hue_raw = word.neg ? HUE_240_W - q_ext - HUE_W'(rem_nz)
                                   : HUE_240_W + q_ext;
            end
            default:
            begin
                hue_raw = '0;
            end
        endcase

        // A gray pixel has a zero spread; its divisions mean nothing.
        saturation_next  = del_nz ? sat_q : '0;
        hue_defined_next = del_nz && (sat_q != '0);
        hue_next         = hue_defined_next ? hue_raw : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg         <= hue_next;
            hue_defined_reg <= hue_defined_next;
            saturation_reg  <= saturation_next;
            brightness_reg  <= word.sat.den;
        end
    end

    assign hue         = hue_reg;
    assign hue_defined = hue_defined_reg;
    assign saturation  = saturation_reg;
    assign brightness  = brightness_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the RGB to HSV converter with randomized flow control.
`timescale 1ns / 1ps

module tb_top;
    import rhc_pkg::*;

    localparam int FULL_CHAN  = (1 << CHANNEL_BITS) - 1;
    localparam int MAX_CYCLES = 250000;
    localparam int MAX_LINES  = 200;
    localparam int NUM_RANDOM = 1150;

    typedef struct {
        logic [CHANNEL_BITS-1:0] r;
        logic [CHANNEL_BITS-1:0] g;
        logic [CHANNEL_BITS-1:0] b;
        bit                      drain_first;
    } pixel_t;

    typedef struct {
        logic [HUE_W-1:0]        hue;
        logic                    defined;
        logic [CHANNEL_BITS-1:0] sat;
        logic [CHANNEL_BITS-1:0] val;
    } hsv_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    pix_valid = 1'b0;
    logic                    pix_stall;
    logic [CHANNEL_BITS-1:0] red = '0;
    logic [CHANNEL_BITS-1:0] green = '0;
    logic [CHANNEL_BITS-1:0] blue = '0;
    logic                    hsv_valid;
    logic                    hsv_stall = 1'b0;
    logic [HUE_W-1:0]        hue;
    logic                    hue_defined;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;

    pixel_t pixels_to_send[$];
    hsv_t   hsv_expected[$];
    bit     pix_taken = 1'b0;
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     stall_mode = 0;
    int     stall_run = 0;

    rgb_to_hsv_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hue        (hue),
        .hue_defined(hue_defined),
        .saturation (saturation),
        .brightness (brightness)
    );

    always #5 clk = ~clk;

    // Converts one pixel the way the block must: max/min, truncated saturation,
    // sextant hue truncated toward zero and wrapped into one turn.
    function automatic hsv_t predict_hsv(input logic [CHANNEL_BITS-1:0] r,
                                         input logic [CHANNEL_BITS-1:0] g,
                                         input logic [CHANNEL_BITS-1:0] b);
        hsv_t    res;
        int      rv, gv, bv, mx, mn, del, sat, diff, base, num, ang;
        sector_t sec;
        rv = r;
        gv = g;
        bv = b;
        mx = rv;
        mn = rv;
        if (gv > mx) mx = gv;
        if (bv > mx) mx = bv;
        if (gv < mn) mn = gv;
        if (bv < mn) mn = bv;
        del = mx - mn;
        sat = (mx != 0) ? (FULL_CHAN * del) / mx : 0;
        res.hue = '0;
        res.defined = 1'b0;
        res.sat = CHANNEL_BITS'(sat);
        res.val = CHANNEL_BITS'(mx);
        if (sat != 0 && del != 0)
        begin
            // Ties go to red first, then green.
            if (rv == mx)
                sec = SEC_RED;
            else if (gv == mx)
                sec = SEC_GREEN;
            else
                sec = SEC_BLUE;
            case (sec)
                SEC_RED:
                begin
                    base = 0;
                    diff = gv - bv;
                end
                SEC_GREEN:
                begin
                    base = HUE_120;
                    diff = bv - rv;
                end
                default:
                begin
                    base = HUE_240;
                    diff = rv - gv;
                end
            endcase
            num = base * del + HUE_SIXTY * diff;
            ang = (num < 0) ? -((-num) / del) : num / del;
            if (ang < 0) ang += HUE_FULL;
            if (ang >= HUE_FULL) ang -= HUE_FULL;
            res.hue = HUE_W'(ang);
            res.defined = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_LINES)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_pixel(input int r, input int g, input int b, input bit drain);
        pixel_t p;
        p.r = CHANNEL_BITS'(r);
        p.g = CHANNEL_BITS'(g);
        p.b = CHANNEL_BITS'(b);
        p.drain_first = drain;
        pixels_to_send.push_back(p);
    endtask

    // Sender: bursts of words separated by random gaps; a flagged word waits
    // until the pipeline has handed back every result.
    always @(negedge clk)
    begin
        pixel_t nxt;
        bit     send;
        if (rst_n && (!pix_valid || pix_taken))
        begin
            send = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pixels_to_send.size() > 0 &&
                     !(pixels_to_send[0].drain_first && hsv_expected.size() > 0))
            begin
                nxt = pixels_to_send.pop_front();
                send = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            pix_valid <= send;
            if (send)
            begin
                red <= nxt.r;
                green <= nxt.g;
                blue <= nxt.b;
            end
        end
    end

    // Receiver: the stall pattern is redrawn at regular intervals from none,
    // random, periodic and long runs.
    always @(negedge clk)
    begin
        bit stall_now;
        if (rst_n)
        begin
            if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: stall_now = 1'b0;
                1: stall_now = ($urandom_range(0, 2) == 0);
                2: stall_now = (cycle_count % 7) < 3;
                default:
                begin
                    if (stall_run == 0)
                        stall_run = ($urandom_range(0, 1) == 0) ?
                                    $urandom_range(1, 20) : -$urandom_range(1, 20);
                    stall_now = stall_run > 0;
                    stall_run = (stall_run > 0) ? stall_run - 1 : stall_run + 1;
                end
            endcase
            hsv_stall <= stall_now;
        end
    end

    // Monitor: record accepted pixels, then check accepted results in order.
    always @(posedge clk)
    begin
        hsv_t want;
        cycle_count++;
        pix_taken = rst_n && pix_valid && !pix_stall;
        if (pix_taken)
            hsv_expected.push_back(predict_hsv(red, green, blue));
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (hsv_expected.size() == 0)
                report_mismatch("result word with nothing outstanding", hue, 0);
            else
            begin
                want = hsv_expected.pop_front();
                if (hue !== want.hue) report_mismatch("hue", hue, want.hue);
                if (hue_defined !== want.defined)
                    report_mismatch("hue_defined", hue_defined, want.defined);
                if (saturation !== want.sat)
                    report_mismatch("saturation", saturation, want.sat);
                if (brightness !== want.val)
                    report_mismatch("brightness", brightness, want.val);
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int mode, v, lo;
        // Gray levels, pure primaries, tied maxima and the red sextant wrap.
        queue_pixel(0, 0, 0, 0);
        queue_pixel(255, 255, 255, 0);
        queue_pixel(128, 128, 128, 0);
        queue_pixel(1, 1, 1, 0);
        queue_pixel(255, 0, 0, 0);
        queue_pixel(0, 255, 0, 0);
        queue_pixel(0, 0, 255, 0);
        queue_pixel(255, 255, 0, 0);
        queue_pixel(0, 255, 255, 0);
        queue_pixel(255, 0, 255, 0);
        queue_pixel(255, 0, 1, 0);
        queue_pixel(200, 10, 20, 0);
        queue_pixel(255, 254, 254, 0);
        queue_pixel(254, 255, 255, 0);
        queue_pixel(1, 0, 0, 0);
        queue_pixel(0, 1, 0, 0);
        queue_pixel(0, 0, 1, 0);
        queue_pixel(170, 85, 0, 0);
        queue_pixel(255, 128, 0, 0);
        queue_pixel(128, 64, 200, 0);
        queue_pixel(10, 200, 200, 0);
        queue_pixel(90, 30, 90, 0);
        queue_pixel(0, 255, 128, 0);
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            mode = $urandom_range(0, 9);
            v = $urandom_range(0, FULL_CHAN);
            lo = $urandom_range(0, v);
            case (mode)
                0: queue_pixel(v, v, v, i == 0);
                1: queue_pixel(v, v, lo, 0);
                2: queue_pixel(lo, v, v, 0);
                3: queue_pixel(v, lo, v, 0);
                4: queue_pixel($urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(0, 3), 0);
                default: queue_pixel($urandom_range(0, FULL_CHAN), $urandom_range(0, FULL_CHAN),
                                     $urandom_range(0, FULL_CHAN),
                                     i == 0 || $urandom_range(0, 299) == 0);
            endcase
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // The sender drops valid only after its last word has been taken.
        while (pixels_to_send.size() > 0 || pix_valid)
            @(posedge clk);
        while (hsv_expected.size() > 0)
            @(posedge clk);
        repeat (2 * PIPE_STAGES + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== rgb_to_hsv_converter.f =====
+incdir+design
design/rhc_pkg.sv
design/rhc_ctrl.sv
design/rhc_front.sv
design/rhc_div_stage.sv
design/rhc_back.sv
design/rgb_to_hsv_converter.sv
tb/sv/tb_top.sv
